// ===== design/mhpq_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the heap queue.
`default_nettype none

package mhpq_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = ADDR_W + 2;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 8;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RD_PARENT,
        RD_LAST,
        RD_CHILD
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        logic    set_status;
        t_status status_code;
        logic    start_up;
        logic    start_dn;
        t_rd_sel rd_sel;
        logic    take_last;
        logic    up_move;
        logic    dn_move;
        logic    wr_val;
        logic    inc_cnt;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  full;
        logic  empty;
        logic  at_root;
        logic  up_gt;
        logic  dn_leaf;
        logic  dn_gt;
        logic  out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== design/mhpq_ctrl.sv =====
// Sequencer for insert/sift-up and remove/sift-down on the heap datapath.
`default_nettype none

module mhpq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire mhpq_pkg::t_stat i_stat,
    output mhpq_pkg::t_cmd      o_cmd
);
    import mhpq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_TAKE,
        S_DN_RD,
        S_DN_CMP,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.mode == MODE_INSERT) begin
                    if (i_stat.full) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_FULL;
                        n_state           = S_FIN;
                    end else begin
                        o_cmd.start_up = 1'b1;
                        n_state        = S_UP_RD;
                    end
                end else begin
                    if (i_stat.empty) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_EMPTY;
                        n_state           = S_FIN;
                    end else begin
                        o_cmd.start_dn = 1'b1;
                        n_state        = S_DN_LAST;
                    end
                end
            end
            S_UP_RD: begin
                o_cmd.rd_sel = RD_PARENT;
                if (i_stat.at_root) begin
                    o_cmd.wr_val  = 1'b1;
                    o_cmd.inc_cnt = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_gt) begin
                    // pull parent down into the hole, climb one level
                    o_cmd.up_move = 1'b1;
                    n_state       = S_UP_RD;
                end else begin
                    o_cmd.wr_val  = 1'b1;
                    o_cmd.inc_cnt = 1'b1;
                    n_state       = S_FIN;
                end
            end
            S_DN_LAST: begin
                o_cmd.rd_sel = RD_LAST;
                n_state      = S_DN_TAKE;
            end
            S_DN_TAKE: begin
                o_cmd.take_last = 1'b1;
                // removing the only entry leaves nothing to place
                n_state = i_stat.empty ? S_FIN : S_DN_RD;
            end
            S_DN_RD: begin
                o_cmd.rd_sel = RD_CHILD;
                if (i_stat.dn_leaf) begin
                    o_cmd.wr_val = 1'b1;
                    n_state      = S_FIN;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_stat.dn_gt) begin
                    o_cmd.dn_move = 1'b1;
                    n_state       = S_DN_RD;
                end else begin
                    o_cmd.wr_val = 1'b1;
                    n_state      = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/mhpq_dp.sv =====
// Heap storage, moving value, hole position, entry count and result register.
`default_nettype none

module mhpq_dp (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mhpq_pkg::t_cmd        i_cmd,
    output mhpq_pkg::t_stat            o_stat,
    input  wire logic                  i_mode,
    input  wire logic signed [31:0]    i_value,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [1:0]                 o_status,
    output logic signed [31:0]         o_top_value,
    output logic                       o_empty_res,
    output logic [7:0]                 o_count
);
    import mhpq_pkg::*;

    logic signed [DATA_W-1:0] mem [CAPACITY];

    logic [CNT_W-1:0]         r_cnt;
    logic [ADDR_W-1:0]        r_pos;
    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] r_root;
    logic signed [DATA_W-1:0] r_rd_a;
    logic signed [DATA_W-1:0] r_rd_b;
    t_mode                    r_mode;
    t_status                  r_status;

    logic                     r_o_valid;
    t_status                  r_o_status;
    logic signed [DATA_W-1:0] r_o_top;
    logic                     r_o_empty;
    logic [COUNT_W-1:0]       r_o_count;

    logic [ADDR_W-1:0]        parent;
    logic [CHILD_W-1:0]       left;
    logic [CHILD_W-1:0]       right;
    logic                     right_in;
    logic                     pick_right;
    logic signed [DATA_W-1:0] pick_val;
    logic [ADDR_W-1:0]        pick_addr;
    logic [ADDR_W-1:0]        addr_a;
    logic [ADDR_W-1:0]        addr_b;
    logic                     wr_en;
    logic signed [DATA_W-1:0] wr_data;

    assign parent     = ADDR_W'(r_pos - ADDR_W'(1)) >> 1;
    assign left       = CHILD_W'({r_pos, 1'b0}) + CHILD_W'(1);
    assign right      = left + CHILD_W'(1);
    assign right_in   = right < CHILD_W'(r_cnt);
    // right child wins a tie
    assign pick_right = right_in && !(r_rd_a > r_rd_b);
    assign pick_val   = pick_right ? r_rd_b : r_rd_a;
    assign pick_addr  = pick_right ? right[ADDR_W-1:0] : left[ADDR_W-1:0];

    always_comb begin
        addr_a = parent;
        addr_b = right[ADDR_W-1:0];
        case (i_cmd.rd_sel)
            RD_PARENT: addr_a = parent;
            RD_LAST:   addr_a = r_cnt[ADDR_W-1:0];
            RD_CHILD:  addr_a = left[ADDR_W-1:0];
            default:   addr_a = parent;
        endcase
    end

    assign wr_en   = i_cmd.wr_val | i_cmd.up_move | i_cmd.dn_move;
    assign wr_data = i_cmd.wr_val  ? r_val :
                     i_cmd.up_move ? r_rd_a : pick_val;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_pos] <= wr_data;
        end
        r_rd_a <= mem[addr_a];
        r_rd_b <= mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.start_dn) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end else if (i_cmd.inc_cnt) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= t_mode'(i_mode);
            r_val    <= i_value;
            r_status <= ST_DONE;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.take_last) begin
            r_val <= r_rd_a;
        end
        if (i_cmd.start_up) begin
            r_pos <= r_cnt[ADDR_W-1:0];
        end else if (i_cmd.start_dn) begin
            r_pos <= '0;
        end else if (i_cmd.up_move) begin
            r_pos <= parent;
        end else if (i_cmd.dn_move) begin
            r_pos <= pick_addr;
        end
        // mirror of entry zero for the result
        if (wr_en && r_pos == '0) begin
            r_root <= wr_data;
        end
        if (i_cmd.emit) begin
            r_o_status <= r_status;
            r_o_top    <= (r_cnt == '0) ? '0 : r_root;
            r_o_empty  <= (r_cnt == '0);
            r_o_count  <= COUNT_W'(r_cnt);
        end
    end

    assign o_stat.mode     = r_mode;
    assign o_stat.full     = (r_cnt == CNT_W'(CAPACITY));
    assign o_stat.empty    = (r_cnt == '0);
    assign o_stat.at_root  = (r_pos == '0);
    assign o_stat.up_gt    = (r_val > r_rd_a);
    assign o_stat.dn_leaf  = (left >= CHILD_W'(r_cnt));
    assign o_stat.dn_gt    = (pick_val > r_val);
    assign o_stat.out_free = !r_o_valid || i_out_ready;

    assign o_out_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_top_value = r_o_top;
    assign o_empty_res = r_o_empty;
    assign o_count     = r_o_count;

endmodule

`default_nettype wire

// ===== design/max_heap_priority_queue.sv =====
// Top level of the binary max-heap priority queue: controller, datapath and stream ports.
//
//  Channel | Direction | tdata                                         | tuser
//  s_axis  | in        | [31:0] value                                  | [0] mode
//  m_axis  | out       | [31:0] top_value, [32] empty_res, [40:33] count | [1:0] status
//
// An insert climbs level by level toward the root; a remove moves the last entry to the root and
// sifts it down, with nothing to place when it empties the heap; a rejected item goes straight to
// the result. At most 7 levels are moved, each a read, a compare, a write.
// Synchronous active-low reset empties the heap; memory contents are not cleared.
// A result waiting on m_axis does not stop the next beat on s_axis; the block stalls
// only when a new result is ready and the previous one has not been taken.
`default_nettype none

module max_heap_priority_queue (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [31:0] value
    input  wire logic [mhpq_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // [0] mode
    input  wire logic [mhpq_pkg::IN_TUSER_W-1:0]    i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [31:0] top_value, [32] empty_res, [40:33] count, [47:41] zero
    output logic [mhpq_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    // [1:0] status
    output logic [mhpq_pkg::OUT_TUSER_W-1:0]        o_m_axis_tuser
);
    import mhpq_pkg::*;

    t_cmd                     cmd;
    t_stat                    stat;
    logic signed [DATA_W-1:0] top_value;
    logic                     empty_res;
    logic [COUNT_W-1:0]       count;
    logic [1:0]               status;

    mhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mhpq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_mode      (i_s_axis_tuser[0]),
        .i_value     (i_s_axis_tdata[DATA_W-1:0]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_status    (status),
        .o_top_value (top_value),
        .o_empty_res (empty_res),
        .o_count     (count)
    );

    assign o_m_axis_tdata = {7'd0, count, empty_res, top_value};
    assign o_m_axis_tuser = status;

endmodule

`default_nettype wire

// ===== design/mhpq_checker.sv =====
// Port-level checks on the heap queue's result stream, bound to the top level.
`default_nettype none

module mhpq_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_m_axis_tvalid,
    input wire logic                               i_m_axis_tready,
    input wire logic [mhpq_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input wire logic [mhpq_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser
);
    import mhpq_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[32] == (o_m_axis_tdata[40:33] == '0)))
        else $error("empty flag disagrees with count");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[32] |-> o_m_axis_tdata[31:0] == '0)
        else $error("empty heap reports nonzero top");

    a_reject_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_EMPTY |-> o_m_axis_tdata[32])
        else $error("remove rejected on a non-empty heap");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_FULL |->
            o_m_axis_tdata[40:33] == COUNT_W'(CAPACITY))
        else $error("insert rejected below capacity");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

// ===== test/tb_max_heap_priority_queue.sv =====
// Stream testbench for the max-heap priority queue: bursty sender, stalling receiver, heap predictor.
`timescale 1ns / 1ps
`default_nettype none

module tb_max_heap_priority_queue;
    import mhpq_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_START    = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 450;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct {
        t_mode       mode;
        logic [31:0] value;
    } t_heap_op;

    typedef struct {
        t_status     status;
        logic [31:0] top_value;
        logic        empty_res;
        logic [7:0]  count;
    } t_heap_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic [IN_TUSER_W-1:0]  s_user = '0;
    logic                   m_ready = 1'b0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;

    max_heap_priority_queue u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    t_heap_op          pending_ops[$];
    t_heap_result      expected_results[$];
    logic signed [31:0] heap_model[CAPACITY];
    int                model_count = 0;
    int                mismatches = 0;
    int                cycle_count = 0;
    logic              rx_hold = 1'b0;

    // Apply one operation to the shadow heap and return the result it must produce.
    function automatic t_heap_result apply_heap_op(t_mode mode, logic [31:0] value);
        t_heap_result       res;
        int                 pos;
        int                 parent;
        int                 left;
        int                 right;
        int                 pick;
        logic               done;
        logic signed [31:0] tmp;
        res.status = ST_DONE;
        if (mode == MODE_INSERT) begin
            if (model_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                pos = model_count;
                heap_model[pos] = value;
                done = 1'b0;
                while (pos > 0 && !done) begin
                    parent = (pos - 1) / 2;
                    if (heap_model[pos] > heap_model[parent]) begin
                        tmp = heap_model[pos];
                        heap_model[pos] = heap_model[parent];
                        heap_model[parent] = tmp;
                        pos = parent;
                    end else begin
                        done = 1'b1;
                    end
                end
                model_count++;
            end
        end else begin
            if (model_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                heap_model[0] = heap_model[model_count - 1];
                model_count--;
                pos = 0;
                done = 1'b0;
                while (!done) begin
                    left = 2 * pos + 1;
                    right = left + 1;
                    if (left >= model_count) begin
                        done = 1'b1;
                    end else begin
                        // ties go to the right child
                        if (right >= model_count || heap_model[left] > heap_model[right])
                            pick = left;
                        else
                            pick = right;
                        if (heap_model[pick] > heap_model[pos]) begin
                            tmp = heap_model[pick];
                            heap_model[pick] = heap_model[pos];
                            heap_model[pos] = tmp;
                            pos = pick;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
            end
        end
        res.top_value = (model_count > 0) ? heap_model[0] : 32'd0;
        res.empty_res = (model_count == 0);
        res.count     = model_count[7:0];
        return res;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000 + $urandom_range(0, 3);
            1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2, 3:    return $urandom_range(0, 9) - 5;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_op(t_mode mode, logic [31:0] value);
        t_heap_op op;
        op.mode  = mode;
        op.value = value;
        pending_ops.push_back(op);
    endfunction

    // Sender: bursts of beats with random gaps between them.
    t_heap_op tx_op;
    logic     tx_next_valid;
    int       tx_burst_left = 4;
    int       tx_gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            s_data  <= '0;
            s_user  <= '0;
        end else begin
            tx_next_valid = s_valid;
            if (s_valid && o_s_axis_tready) begin
                expected_results.push_back(apply_heap_op(tx_op.mode, tx_op.value));
                tx_next_valid = 1'b0;
            end
            if (!tx_next_valid) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                end else if (pending_ops.size() > 0) begin
                    tx_op = pending_ops.pop_front();
                    tx_next_valid = 1'b1;
                    s_data <= tx_op.value;
                    s_user <= tx_op.mode;
                    if (tx_burst_left <= 1) begin
                        tx_burst_left = $urandom_range(1, 16);
                        tx_gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        tx_burst_left--;
                    end
                end
            end
            s_valid <= tx_next_valid;
        end
    end

    // Cycle count, long receiver hold-off and timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        rx_hold <= (cycle_count >= HOLD_START) && (cycle_count < HOLD_START + HOLD_CYCLES);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: stall pattern changes per window of random length.
    int rx_window_left = 0;
    int rx_pattern = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_window_left == 0) begin
                rx_window_left = $urandom_range(8, 80);
                rx_pattern = $urandom_range(0, 2);
            end else begin
                rx_window_left--;
            end
            if (rx_hold)
                m_ready <= 1'b0;
            else if (rx_pattern == 0)
                m_ready <= 1'b1;
            else if (rx_pattern == 1)
                m_ready <= 1'($urandom_range(0, 1));
            else
                m_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // Monitor: compare each accepted result beat with the oldest expectation.
    t_heap_result rx_want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat tdata=%h tuser=%h",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
                mismatches++;
            end else begin
                rx_want = expected_results.pop_front();
                if (o_m_axis_tuser[1:0] !== rx_want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, rx_want.status, o_m_axis_tuser[1:0]);
                    mismatches++;
                end
                if (o_m_axis_tdata[31:0] !== rx_want.top_value) begin
                    $display("%0t: top_value expected %h actual %h",
                             $time, rx_want.top_value, o_m_axis_tdata[31:0]);
                    mismatches++;
                end
                if (o_m_axis_tdata[32] !== rx_want.empty_res) begin
                    $display("%0t: empty_res expected %b actual %b",
                             $time, rx_want.empty_res, o_m_axis_tdata[32]);
                    mismatches++;
                end
                if (o_m_axis_tdata[40:33] !== rx_want.count) begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, rx_want.count, o_m_axis_tdata[40:33]);
                    mismatches++;
                end
            end
        end
    end

    int gen_count;
    int gen_items;
    int extra;

    initial begin
        // Directed: empty remove, extreme values, equal values, drain past empty.
        queue_op(MODE_REMOVE, 32'hFFFF_FFFF);
        queue_op(MODE_INSERT, 32'h8000_0000);
        queue_op(MODE_INSERT, 32'h7FFF_FFFF);
        queue_op(MODE_INSERT, 32'h0000_0000);
        queue_op(MODE_INSERT, 32'hFFFF_FFFF);
        queue_op(MODE_INSERT, 32'h0000_0001);
        queue_op(MODE_INSERT, 32'h5555_5555);
        queue_op(MODE_INSERT, 32'hAAAA_AAAA);
        queue_op(MODE_INSERT, 32'h7FFF_FFFF);
        queue_op(MODE_INSERT, 32'h0000_0001);
        queue_op(MODE_INSERT, 32'h0000_0001);
        for (int i = 0; i < 11; i++)
            queue_op(MODE_REMOVE, $urandom);
        queue_op(MODE_REMOVE, 32'h0000_0000);

        // Random: fill to full and beyond, drain to empty and beyond, then mix.
        gen_count = 0;
        gen_items = 0;
        extra = 0;
        while (extra < 3) begin
            if (gen_count < CAPACITY && $urandom_range(0, 9) == 0) begin
                queue_op(MODE_REMOVE, $urandom);
                if (gen_count > 0) gen_count--;
            end else begin
                queue_op(MODE_INSERT, pick_value());
                if (gen_count < CAPACITY) gen_count++;
                else extra++;
            end
            gen_items++;
        end
        extra = 0;
        while (extra < 2) begin
            if (gen_count > 0 && $urandom_range(0, 6) == 0) begin
                queue_op(MODE_INSERT, pick_value());
                gen_count++;
            end else begin
                queue_op(MODE_REMOVE, $urandom);
                if (gen_count > 0) gen_count--;
                else extra++;
            end
            gen_items++;
        end
        while (gen_items < RANDOM_ITEMS) begin
            queue_op(t_mode'($urandom_range(0, 1)), pick_value());
            gen_items++;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (pending_ops.size() > 0 || s_valid || expected_results.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/mhpq_pkg.sv
design/mhpq_ctrl.sv
design/mhpq_dp.sv
design/max_heap_priority_queue.sv
design/mhpq_checker.sv
test/tb_max_heap_priority_queue.sv
